FILE: sv/one_shot_timer_pool_core_defines.svh
// ----------------------------------------------------------------------------
// one_shot_timer_pool_core_defines: assertion macros
// shared concurrent assertion forms for the timer pool rtl
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_POOL_CORE_DEFINES_SVH
`define ONE_SHOT_TIMER_POOL_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define OSTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ostp: assertion failed");

// next-cycle implication, disabled while in reset
`define OSTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ostp: assertion failed");

`endif

FILE: sv/ostp_pkg.sv
// ----------------------------------------------------------------------------
// ostp_pkg: timer pool types and constants
// operation codes, result word layout and sequencer states
// ----------------------------------------------------------------------------
package ostp_pkg;

	localparam int unsigned OP_W       = 3;
	localparam int unsigned ID_W       = 4;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned SLOT_W     = 3;
	localparam int unsigned MAX_EVENTS = 8;
	localparam int unsigned EVT_CNT_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE = 3'd0,
		OP_RUN    = 3'd1,
		OP_HALT   = 3'd2,
		OP_DELETE = 3'd3,
		OP_TICK   = 3'd4
	} op_t;

	typedef enum logic {
		KIND_REPLY  = 1'b0,
		KIND_EXPIRY = 1'b1
	} kind_t;

	typedef enum logic {
		ST_OK  = 1'b0,
		ST_ERR = 1'b1
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_RUN,
		S_SCAN,
		S_FLUSH,
		S_REPLY
	} seq_state_t;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] slot;
		logic              status;
		logic              last;
	} res_t;

endpackage

FILE: sv/ostp_cmd_if.sv
// ----------------------------------------------------------------------------
// ostp_cmd_if: command channel
// valid/ready channel carrying one timer operation per word
// ----------------------------------------------------------------------------
interface ostp_cmd_if import ostp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ID_W-1:0]   timer_id;
	logic [TIME_W-1:0] interval_ms;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, output op, output timer_id, output interval_ms,
		output now_ms, input ready);
	modport sink (input valid, input op, input timer_id, input interval_ms,
		input now_ms, output ready);
endinterface

FILE: sv/ostp_res_if.sv
// ----------------------------------------------------------------------------
// ostp_res_if: result channel
// valid/ready channel carrying replies and expiry events
// ----------------------------------------------------------------------------
interface ostp_res_if import ostp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [SLOT_W-1:0] slot;
	logic              status;
	logic              last;

	modport source (output valid, output kind, output slot, output status,
		output last, input ready);
	modport sink (input valid, input kind, input slot, input status,
		input last, output ready);
endinterface

FILE: sv/ostp_ram.sv
// ----------------------------------------------------------------------------
// ostp_ram: simple dual-port memory
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module ostp_ram #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned WIDTH = 32,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/ostp_obuf.sv
// ----------------------------------------------------------------------------
// ostp_obuf: result output register
// one-word register that decouples the sequencer from the result sink
// ----------------------------------------------------------------------------
module ostp_obuf import ostp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_word,
	ostp_res_if.source rsp
);

	logic full_q;
	res_t word_q;

	// take a new word when empty or when the held one leaves this cycle
	assign in_ready = !full_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ready) begin
			full_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q <= in_word;
		end
	end

	assign rsp.valid  = full_q;
	assign rsp.kind   = word_q.kind;
	assign rsp.slot   = word_q.slot;
	assign rsp.status = word_q.status;
	assign rsp.last   = word_q.last;

endmodule

FILE: sv/ostp_seq.sv
// ----------------------------------------------------------------------------
// ostp_seq: timer pool sequencer
// per-slot flags, operation decode, free-slot search and expiry scan
// ----------------------------------------------------------------------------
`include "one_shot_timer_pool_core_defines.svh"

module ostp_seq import ostp_pkg::*; #(
	parameter int unsigned NUM_TIMERS = 8,
	parameter int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	ostp_cmd_if.sink cmd,
	// interval memory
	output logic              ivl_we,
	output logic [IW-1:0]     ivl_waddr,
	output logic [TIME_W-1:0] ivl_wdata,
	output logic              ivl_re,
	output logic [IW-1:0]     ivl_raddr,
	input  logic [TIME_W-1:0] ivl_rdata,
	// deadline memory
	output logic              dl_we,
	output logic [IW-1:0]     dl_waddr,
	output logic [TIME_W-1:0] dl_wdata,
	output logic              dl_re,
	output logic [IW-1:0]     dl_raddr,
	input  logic [TIME_W-1:0] dl_rdata,
	// result word
	output logic res_valid,
	input  logic res_ready,
	output res_t res_word
);

	localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
	localparam int unsigned XW = (CW > ID_W) ? CW : ID_W;
	localparam logic [CW-1:0] SLOT_CNT = CW'(NUM_TIMERS);

	seq_state_t state_q, state_d;

	logic [NUM_TIMERS-1:0] alloc_q;
	logic [NUM_TIMERS-1:0] armed_q;
	logic [TIME_W-1:0]     now_q;
	logic [TIME_W-1:0]     ivl_q;
	logic [IW-1:0]         idx_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  status_q;
	logic [CW-1:0]         iss_q;
	logic                  chk_v_s1;
	logic [IW-1:0]         chk_idx_s1;
	logic                  pend_v_q;
	logic [IW-1:0]         pend_idx_q;
	logic [EVT_CNT_W-1:0]  ev_cnt_q;

	logic          accept;
	logic [XW-1:0] id_x;
	logic          id_ok;
	logic [IW-1:0] id_idx;
	logic          is_slot_op;
	logic          iss_live;
	logic [IW-1:0] iss_idx;
	logic          free_hit;
	logic          exp_hit;
	logic          stall;
	logic          hit_go;
	logic          ev_full;
	logic          scan_done;

	assign cmd.ready  = (state_q == S_IDLE);
	assign accept     = cmd.valid && cmd.ready;
	assign id_x       = XW'(cmd.timer_id);
	assign id_ok      = id_x < XW'(NUM_TIMERS);
	assign id_idx     = IW'(cmd.timer_id);
	assign is_slot_op = (cmd.op inside {OP_RUN, OP_HALT, OP_DELETE});

	assign iss_live  = iss_q < SLOT_CNT;
	assign iss_idx   = iss_q[IW-1:0];
	assign free_hit  = !alloc_q[iss_idx];
	assign exp_hit   = chk_v_s1 && alloc_q[chk_idx_s1] && armed_q[chk_idx_s1]
		&& (now_q > dl_rdata);
	assign stall     = exp_hit && pend_v_q && !res_ready;
	assign hit_go    = (state_q == S_SCAN) && exp_hit && !stall;
	assign ev_full   = ev_cnt_q == EVT_CNT_W'(MAX_EVENTS - 1);
	assign scan_done = !iss_live && !chk_v_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd.op)
						OP_CREATE: state_d = (cmd.interval_ms == '0) ? S_REPLY : S_FIND;
						OP_RUN:    state_d = (id_ok && alloc_q[id_idx]) ? S_RUN : S_REPLY;
						OP_TICK:   state_d = S_SCAN;
						default:   state_d = S_REPLY;
					endcase
				end
			end
			S_FIND: begin
				if (!iss_live || free_hit) state_d = S_REPLY;
			end
			S_RUN: state_d = S_REPLY;
			S_SCAN: begin
				if (hit_go && ev_full) begin
					state_d = S_FLUSH;
				end else if (scan_done) begin
					state_d = pend_v_q ? S_FLUSH : S_IDLE;
				end
			end
			S_FLUSH: begin
				if (res_ready) state_d = S_IDLE;
			end
			S_REPLY: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: result word and memory ports
	always_comb begin
		res_valid       = 1'b0;
		res_word.kind   = KIND_REPLY;
		res_word.slot   = slot_q;
		res_word.status = status_q;
		res_word.last   = 1'b1;
		ivl_we    = 1'b0;
		ivl_waddr = iss_idx;
		ivl_wdata = ivl_q;
		ivl_re    = 1'b0;
		ivl_raddr = id_idx;
		dl_we     = 1'b0;
		dl_waddr  = idx_q;
		dl_wdata  = now_q + ivl_rdata;
		dl_re     = 1'b0;
		dl_raddr  = iss_idx;
		unique case (state_q)
			S_IDLE: begin
				ivl_re = accept && (cmd.op == OP_RUN) && id_ok;
			end
			S_FIND: begin
				ivl_we = iss_live && free_hit;
			end
			S_RUN: begin
				dl_we = 1'b1;
			end
			S_SCAN: begin
				// a new hit pushes the held event out as a non-final word
				res_valid       = exp_hit && pend_v_q;
				res_word.kind   = KIND_EXPIRY;
				res_word.slot   = SLOT_W'(pend_idx_q);
				res_word.status = ST_OK;
				res_word.last   = 1'b0;
				dl_re           = iss_live && !stall && !(hit_go && ev_full);
			end
			S_FLUSH: begin
				res_valid       = 1'b1;
				res_word.kind   = KIND_EXPIRY;
				res_word.slot   = SLOT_W'(pend_idx_q);
				res_word.status = ST_OK;
				res_word.last   = 1'b1;
			end
			S_REPLY: begin
				res_valid = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			alloc_q  <= '0;
			armed_q  <= '0;
			iss_q    <= '0;
			chk_v_s1 <= 1'b0;
			pend_v_q <= 1'b0;
			ev_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				iss_q    <= '0;
				chk_v_s1 <= 1'b0;
				pend_v_q <= 1'b0;
				ev_cnt_q <= '0;
				if (id_ok && (cmd.op == OP_HALT)) begin
					armed_q[id_idx] <= 1'b0;
				end
				if (id_ok && (cmd.op == OP_DELETE)) begin
					alloc_q[id_idx] <= 1'b0;
					armed_q[id_idx] <= 1'b0;
				end
			end
			if (state_q == S_FIND && iss_live) begin
				if (free_hit) begin
					alloc_q[iss_idx] <= 1'b1;
					armed_q[iss_idx] <= 1'b0;
				end else begin
					iss_q <= iss_q + 1'b1;
				end
			end
			if (state_q == S_RUN) begin
				armed_q[idx_q] <= 1'b1;
			end
			if (state_q == S_SCAN && !stall) begin
				chk_v_s1 <= iss_live;
				if (iss_live) iss_q <= iss_q + 1'b1;
				if (hit_go) begin
					alloc_q[chk_idx_s1] <= 1'b0;
					armed_q[chk_idx_s1] <= 1'b0;
					pend_v_q            <= 1'b1;
					ev_cnt_q            <= ev_cnt_q + 1'b1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= cmd.now_ms;
			ivl_q    <= cmd.interval_ms;
			idx_q    <= id_idx;
			slot_q   <= '0;
			status_q <= (is_slot_op && id_ok) ? ST_OK : ST_ERR;
		end
		if (state_q == S_FIND && iss_live && free_hit) begin
			slot_q   <= SLOT_W'(iss_idx);
			status_q <= ST_OK;
		end
		if (state_q == S_SCAN && !stall) begin
			chk_idx_s1 <= iss_idx;
			if (hit_go) pend_idx_q <= chk_idx_s1;
		end
	end

	`OSTP_ASSERT_IMP(a_armed_in_alloc, clk, arst_n, 1'b1, (armed_q & ~alloc_q) == '0)
	`OSTP_ASSERT_IMP(a_expiry_ok, clk, arst_n, res_valid && res_word.kind, !res_word.status)
	`OSTP_ASSERT_NXT(a_hit_frees, clk, arst_n, hit_go, !alloc_q[$past(chk_idx_s1)])
	`OSTP_ASSERT_NXT(a_create_takes, clk, arst_n, ivl_we, alloc_q[$past(ivl_waddr)] && !armed_q[$past(ivl_waddr)])

endmodule

FILE: sv/one_shot_timer_pool_core.sv
// ----------------------------------------------------------------------------
// one_shot_timer_pool_core: pool of one-shot millisecond timers
// create, run, halt, delete and tick over NUM_TIMERS slots
// ----------------------------------------------------------------------------
// One command word is taken at a time; cmd.ready is high only while the pool
// is idle. Halt, delete and rejected commands go from accept straight to the
// reply word, run of an allocated slot passes through an interval read and a
// deadline write, and create with a nonzero interval walks occupied slots
// until a free one is found (the whole pool when it is full). A tick walks the
// deadline memory one slot per cycle through its single read port, unless a
// new hit waits on a stalled result sink; when slots expire, the final event
// follows from a flush state after the walk ends. A tick with no expired slot
// gives no word at all, otherwise its final event carries last. At most 8
// events come from one tick; the walk stops at the eighth and further expired
// slots stay armed for the next tick. The allocated and armed flags are
// flip-flops cleared by reset, so the pool is usable as soon as reset is
// released, with no clearing pass. Result words leave through a one-word
// output register, so the next command can be accepted while the previous
// reply waits.

module one_shot_timer_pool_core import ostp_pkg::*; #(
	parameter int unsigned NUM_TIMERS = 8
) (
	input  logic clk,
	input  logic arst_n,
	ostp_cmd_if.sink   cmd,
	ostp_res_if.source rsp
);

	// slot index width
	localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	// interval memory: written by create, read by run
	logic              ivl_we;
	logic [IW-1:0]     ivl_waddr;
	logic [TIME_W-1:0] ivl_wdata;
	logic              ivl_re;
	logic [IW-1:0]     ivl_raddr;
	logic [TIME_W-1:0] ivl_rdata;

	// deadline memory: written by run, swept by tick
	logic              dl_we;
	logic [IW-1:0]     dl_waddr;
	logic [TIME_W-1:0] dl_wdata;
	logic              dl_re;
	logic [IW-1:0]     dl_raddr;
	logic [TIME_W-1:0] dl_rdata;

	// sequencer to output register
	logic res_valid;
	logic res_ready;
	res_t res_word;

	// control: decode, flags, free-slot walk and expiry scan;
	// commands are strictly serial, so no memory entry is read and
	// written in overlapping cycles and no forwarding is needed
	ostp_seq #(
		.NUM_TIMERS (NUM_TIMERS),
		.IW         (IW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ivl_we    (ivl_we),
		.ivl_waddr (ivl_waddr),
		.ivl_wdata (ivl_wdata),
		.ivl_re    (ivl_re),
		.ivl_raddr (ivl_raddr),
		.ivl_rdata (ivl_rdata),
		.dl_we     (dl_we),
		.dl_waddr  (dl_waddr),
		.dl_wdata  (dl_wdata),
		.dl_re     (dl_re),
		.dl_raddr  (dl_raddr),
		.dl_rdata  (dl_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	// per-slot intervals, contents undefined until create writes them
	ostp_ram #(
		.DEPTH (NUM_TIMERS),
		.WIDTH (TIME_W),
		.AW    (IW)
	) u_ivl_ram (
		.clk   (clk),
		.we    (ivl_we),
		.waddr (ivl_waddr),
		.wdata (ivl_wdata),
		.re    (ivl_re),
		.raddr (ivl_raddr),
		.rdata (ivl_rdata)
	);

	// per-slot deadlines, read for every slot that a tick walks
	ostp_ram #(
		.DEPTH (NUM_TIMERS),
		.WIDTH (TIME_W),
		.AW    (IW)
	) u_dl_ram (
		.clk   (clk),
		.we    (dl_we),
		.waddr (dl_waddr),
		.wdata (dl_wdata),
		.re    (dl_re),
		.raddr (dl_raddr),
		.rdata (dl_rdata)
	);

	// output register toward the result sink
	ostp_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_ready (res_ready),
		.in_word  (res_word),
		.rsp      (rsp)
	);

endmodule
